>>> hdl/gvmm_pkg.sv
// Shared constants, types and helper functions of the GF(2) vector-matrix multiplier.
package gvmm_pkg;

  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 256;
  localparam int WORD_BITS = 64;
  localparam int ROW_WORDS = (MAX_COLS + WORD_BITS - 1) / WORD_BITS;

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int WI_W  = 2;
  localparam int BIT_W = $clog2(WORD_BITS);
  localparam int CFG_W = 9;
  localparam int OP_W  = 2;

  // Stream word layouts, lowest field first, padded to whole bytes.
  localparam int IN_FIELDS_W  = ROW_W + WI_W + WORD_BITS;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = WI_W + WORD_BITS;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE    = 2'd0,
    OP_PRELOAD  = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_MULTIPLY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef logic [WORD_BITS-1:0] word_t;

  // Clamp a register value into 1 .. max.
  function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] max);
    logic [CFG_W-1:0] r;
    if (v == '0) r = CFG_W'(1);
    else if (v > max) r = max;
    else r = v;
    return r;
  endfunction

  // Mask of the used columns inside word k.
  function automatic word_t col_mask(input logic [WI_W-1:0] k,
                                     input logic [CFG_W-1:0] cols);
    logic [CFG_W-1:0] base;
    logic [CFG_W-1:0] n;
    word_t            m;
    base = CFG_W'(k) << BIT_W;
    n    = cols - base;
    if (cols <= base) m = '0;
    else if (n >= CFG_W'(WORD_BITS)) m = '1;
    else m = (word_t'(1) << n[BIT_W-1:0]) - word_t'(1);
    return m;
  endfunction

endpackage

>>> hdl/gvmm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gvmm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/gf2_vector_matrix_multiply.sv
// GF(2) vector-matrix multiply-accumulate top level.
// Computes acc = acc ^ (v * A) over GF(2). The matrix lives in four 256x64 RAMs, one per
// word position of a row, so a whole row is read at once. Matrix writes, accumulator
// preloads and clears leave the input ready for the next word. A vector word is taken,
// then its bits are walked, reading one matrix row per bit, and a drain state applies the
// last XOR. A word marked last then streams out ceil(cols_in_use/64) result words, one per
// cycle while the sink takes them; the input waits during that time.
// The final result word sits in an output register, so the next item is taken while it waits.
module gf2_vector_matrix_multiply
  import gvmm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input words
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // row, word_index, data, zero pad
  input  logic [OP_W-1:0]        s_axis_tuser,  // op
  input  logic                   s_axis_tlast,
  // Result words
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // word_index_res, data_res, zero pad
  output logic                   m_axis_tlast,
  // Configuration writes
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  state_e state_q, state_d;

  logic [ROW_W-1:0]     in_row;
  logic [WI_W-1:0]      in_wi;
  word_t                in_data;
  op_e                  in_op;
  logic                 in_acc;

  logic [CFG_W-1:0]     rows_q, cols_q;
  logic [CFG_W-1:0]     rows_eff, cols_eff;
  logic [CFG_W-1:0]     cols_m1;
  logic [WI_W-1:0]      used_m1;

  word_t                vec_q, vec_d;
  logic [WI_W-1:0]      vwi_q, vwi_d;
  logic                 vlast_q, vlast_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic                 sel_q, sel_d;
  logic [WI_W-1:0]      k_q, k_d;

  word_t                acc_q [ROW_WORDS];
  word_t                acc_d [ROW_WORDS];
  word_t                mask  [ROW_WORDS];
  word_t                rdata [ROW_WORDS];

  logic                 out_valid_q, out_valid_d;
  logic [WI_W-1:0]      out_wi_q, out_wi_d;
  word_t                out_data_q, out_data_d;
  logic                 out_last_q, out_last_d;
  logic                 out_load;
  logic                 rd_en;
  logic [ROW_W-1:0]     rd_addr;

  assign in_row  = s_axis_tdata[ROW_W-1:0];
  assign in_wi   = s_axis_tdata[ROW_W+WI_W-1:ROW_W];
  assign in_data = s_axis_tdata[IN_FIELDS_W-1:ROW_W+WI_W];
  assign in_op   = op_e'(s_axis_tuser);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign rows_eff = clamp_cfg(rows_q, CFG_W'(MAX_ROWS));
  assign cols_eff = clamp_cfg(cols_q, CFG_W'(MAX_COLS));
  assign cols_m1  = cols_eff - CFG_W'(1);
  assign used_m1  = WI_W'(cols_m1 >> BIT_W);

  always_comb begin
    for (int k = 0; k < ROW_WORDS; k++) begin
      mask[k] = col_mask(WI_W'(k), cols_eff);
    end
  end

  // Row address of the vector bit under work.
  assign rd_addr = ROW_W'({vwi_q, bit_q});
  assign rd_en   = (state_q == ST_MUL);

  for (genvar g = 0; g < ROW_WORDS; g++) begin : g_mat
    gvmm_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(MAX_ROWS)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (in_acc && (in_op == OP_WRITE) && (in_wi == WI_W'(g))),
      .waddr_i(in_row),
      .wdata_i(in_data),
      .re_i   (rd_en),
      .raddr_i(rd_addr),
      .rdata_o(rdata[g])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_op == OP_MULTIPLY)) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (bit_q == '1) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = vlast_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_load && (k_q == used_m1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    out_load      = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

    vec_d   = vec_q;
    vwi_d   = vwi_q;
    vlast_d = vlast_q;
    bit_d   = bit_q;
    k_d     = k_q;
    if (in_acc && (in_op == OP_MULTIPLY)) begin
      vec_d   = in_data;
      vwi_d   = in_wi;
      vlast_d = s_axis_tlast;
      bit_d   = '0;
      k_d     = '0;
    end else if (state_q == ST_MUL) begin
      bit_d = bit_q + BIT_W'(1);
    end
    if (out_load) k_d = k_q + WI_W'(1);

    // Read issued this cycle is applied next cycle.
    sel_d = rd_en && vec_q[bit_q] && ({1'b0, rd_addr} < rows_eff);

    for (int k = 0; k < ROW_WORDS; k++) begin
      acc_d[k] = acc_q[k];
      if (in_acc && (in_op == OP_CLEAR)) begin
        acc_d[k] = '0;
      end else if (in_acc && (in_op == OP_PRELOAD) && (in_wi == WI_W'(k))) begin
        acc_d[k] = in_data;
      end else if (sel_q && (WI_W'(k) <= used_m1)) begin
        acc_d[k] = (acc_q[k] ^ rdata[k]) & mask[k];
      end
    end

    out_valid_d = out_valid_q;
    out_wi_d    = out_wi_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_wi_d    = k_q;
      out_data_d  = acc_q[k_q] & mask[k_q];
      out_last_d  = (k_q == used_m1);
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_q      <= CFG_W'(MAX_ROWS);
      cols_q      <= CFG_W'(MAX_COLS);
      bit_q       <= '0;
      k_q         <= '0;
      sel_q       <= 1'b0;
      vlast_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < ROW_WORDS; k++) begin
        acc_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      bit_q       <= bit_d;
      k_q         <= k_d;
      sel_q       <= sel_d;
      vlast_q     <= vlast_d;
      out_valid_q <= out_valid_d;
      for (int k = 0; k < ROW_WORDS; k++) begin
        acc_q[k] <= acc_d[k];
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ROWS) rows_q <= cfg_data_i;
        if (cfg_index_i == CFG_COLS) cols_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q      <= vec_d;
    vwi_q      <= vwi_d;
    out_wi_q   <= out_wi_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_data_q, out_wi_q});

endmodule

>>> hdl/gvmm_checker.sv
// Port-level checks for the GF(2) vector-matrix multiplier, bound to the top level.
module gvmm_checker
  import gvmm_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [OP_W-1:0]        s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result word changed while stalled");

  // A vector word blocks the input while its bits are worked through.
  a_mul_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_MULTIPLY)) |=> !s_axis_tready)
    else $error("input taken during a multiply");

  // Words of one result follow back to back with rising positions.
  a_out_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid &&
       (m_axis_tdata[WI_W-1:0] == WI_W'($past(m_axis_tdata[WI_W-1:0]) + WI_W'(1)))))
    else $error("result word sequence broken");

  // A result only starts after a busy cycle of the multiply.
  a_out_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result word appeared without a multiply");

endmodule

bind gf2_vector_matrix_multiply gvmm_checker u_gvmm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

>>> tb/sv/tb_top.sv
// Testbench for the GF(2) vector-matrix multiplier: stream stimulus, row/accumulator predictor.
`timescale 1ns / 100ps

module tb_top;
  import gvmm_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 200;   // leave ample room for a vector word in flight
  localparam int PHASES        = 7;
  localparam int PHASE_WORDS   = 47;

  typedef struct packed {
    logic [WI_W-1:0] wi;
    word_t           data;
    logic            is_last;
  } acc_word_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // row, word_index, data, zero pad
  logic [OP_W-1:0]        s_axis_tuser;   // op
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // word_index_res, data_res, zero pad
  logic                   m_axis_tlast;
  logic                   cfg_we_i;
  logic                   cfg_index_i;
  logic [CFG_W-1:0]       cfg_data_i;

  gf2_vector_matrix_multiply i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor state
  word_t            mat_words   [MAX_ROWS][ROW_WORDS];
  bit               mat_written [MAX_ROWS][ROW_WORDS];
  word_t            acc_words   [ROW_WORDS];
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  acc_word_t        acc_expected_q[$];

  int  n_items;
  int  n_results;
  int  n_errors;
  int  n_settings;
  int  cycle_count;
  int  rx_stall_left;
  bit  calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d result words still pending", $realtime,
               acc_expected_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic word_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int sat_reg(input logic [CFG_W-1:0] v, input int max);
    if (v == '0) return 1;
    if (int'(v) > max) return max;
    return int'(v);
  endfunction

  // Used-column mask inside accumulator word k
  function automatic word_t col_window(input int k, input int cols);
    int base;
    int n;
    base = k * WORD_BITS;
    if (cols <= base) return '0;
    n = cols - base;
    if (n >= WORD_BITS) return '1;
    return (word_t'(1) << n) - word_t'(1);
  endfunction

  function automatic bit row_complete(input int r);
    for (int k = 0; k < ROW_WORDS; k++)
      if (!mat_written[r][k]) return 1'b0;
    return 1'b1;
  endfunction

  // Vector bits that never select a row holding unwritten words
  function automatic word_t usable_bits(input logic [WI_W-1:0] wi);
    word_t m;
    int    r;
    int    rows;
    rows = sat_reg(rows_reg, MAX_ROWS);
    m = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      r = int'(wi) * WORD_BITS + b;
      if (r >= rows || row_complete(r)) m[b] = 1'b1;
    end
    return m;
  endfunction

  task automatic predict_word(input op_e op, input logic [7:0] row,
                              input logic [WI_W-1:0] wi, input word_t data,
                              input logic is_last);
    int        cols;
    int        rows;
    int        used;
    int        r;
    acc_word_t res;
    cols = sat_reg(cols_reg, MAX_COLS);
    rows = sat_reg(rows_reg, MAX_ROWS);
    used = (cols + WORD_BITS - 1) / WORD_BITS;
    case (op)
      OP_WRITE: begin
        mat_words[row][wi]   = data;
        mat_written[row][wi] = 1'b1;
      end
      OP_PRELOAD: acc_words[wi] = data;
      OP_CLEAR: begin
        for (int k = 0; k < ROW_WORDS; k++) acc_words[k] = '0;
      end
      OP_MULTIPLY: begin
        for (int b = 0; b < WORD_BITS; b++) begin
          r = int'(wi) * WORD_BITS + b;
          if (data[b] && r < rows) begin
            // every XOR step rewrites all used words under the column mask
            for (int k = 0; k < used; k++)
              acc_words[k] = (acc_words[k] ^ mat_words[r][k]) & col_window(k, cols);
          end
        end
        if (is_last) begin
          for (int k = 0; k < used; k++) begin
            res.wi      = WI_W'(k);
            res.data    = acc_words[k] & col_window(k, cols);
            res.is_last = (k + 1 == used);
            acc_expected_q.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input op_e op, input logic [7:0] row,
                           input logic [WI_W-1:0] wi, input word_t data,
                           input logic is_last);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tlast  <= is_last;
    s_axis_tdata  <= IN_TDATA_W'({data, wi, row});
    do @(posedge clk_i); while (!s_axis_tready);
    predict_word(op, row, wi, data, is_last);
    n_items++;
  endtask

  // Hold the input until all results are back and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (acc_expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ROWS;
    cfg_data_i  <= rows;
    @(posedge clk_i);
    cfg_index_i <= CFG_COLS;
    cfg_data_i  <= cols;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    rows_reg = rows;
    cols_reg = cols;
    n_settings++;
  endtask

  function automatic logic [CFG_W-1:0] pick_reg_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'(256);
      3:       return '1;
      4:       return CFG_W'(64);
      5:       return CFG_W'(65);
      6:       return CFG_W'($urandom_range(2, 255));
      default: return CFG_W'($urandom_range(257, 511));
    endcase
  endfunction

  function automatic logic [7:0] pick_row();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 3) * 64 + $urandom_range(0, 11));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic word_t pick_data();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  task automatic write_full_row(input logic [7:0] row);
    int start;
    start = $urandom_range(0, 3);
    for (int i = 0; i < ROW_WORDS; i++)
      send_word(OP_WRITE, row, WI_W'((start + i) % ROW_WORDS), pick_data(),
                1'($urandom_range(0, 1)));
  endtask

  task automatic run_vector(input int n, input bit with_last);
    logic [WI_W-1:0] wi;
    word_t           d;
    for (int i = 0; i < n; i++) begin
      wi = WI_W'($urandom_range(0, 3));
      d  = ($urandom_range(0, 4) == 0) ? usable_bits(wi) : (rand64() & usable_bits(wi));
      send_word(OP_MULTIPLY, 8'($urandom), wi, d, with_last && (i == n - 1));
    end
  endtask

  // Result checker and sink-side backpressure
  always @(posedge clk_i) begin
    acc_word_t want;
    int        r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (acc_expected_q.size() == 0) begin
        $display("%0t: unexpected result word, got word_index %0d data %h last %b",
                 $realtime, m_axis_tdata[WI_W-1:0], m_axis_tdata[WI_W +: WORD_BITS],
                 m_axis_tlast);
        n_errors++;
      end else begin
        want = acc_expected_q.pop_front();
        if (m_axis_tdata[WI_W-1:0] !== want.wi) begin
          $display("%0t: word_index mismatch, expected %0d got %0d", $realtime,
                   want.wi, m_axis_tdata[WI_W-1:0]);
          n_errors++;
        end
        if (m_axis_tdata[WI_W +: WORD_BITS] !== want.data) begin
          $display("%0t: data mismatch at word %0d, expected %h got %h", $realtime,
                   want.wi, want.data, m_axis_tdata[WI_W +: WORD_BITS]);
          n_errors++;
        end
        if (m_axis_tlast !== want.is_last) begin
          $display("%0t: last mismatch at word %0d, expected %b got %b", $realtime,
                   want.wi, want.is_last, m_axis_tlast);
          n_errors++;
        end
      end
    end
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else if (calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        if (r >= 92) rx_stall_left = $urandom_range(5, 30);
      end
    end
  end

  task automatic test_reset_state();
    // accumulator starts at zero, full width after reset
    send_word(OP_MULTIPLY, 8'h00, 2'd2, '0, 1'b1);
  endtask

  task automatic test_directed_ops();
    send_word(OP_WRITE, 8'd0, 2'd0, '1, 1'b0);
    send_word(OP_WRITE, 8'd0, 2'd1, '0, 1'b1);
    send_word(OP_WRITE, 8'd0, 2'd2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_word(OP_WRITE, 8'd0, 2'd3, 64'h8000_0000_0000_0001, 1'b0);
    for (int k = ROW_WORDS - 1; k >= 0; k--)
      send_word(OP_WRITE, 8'd255, WI_W'(k), rand64(), 1'(k & 1));
    send_word(OP_MULTIPLY, 8'hFF, 2'd0, 64'h1, 1'b0);
    send_word(OP_MULTIPLY, 8'h00, 2'd3, 64'h8000_0000_0000_0000, 1'b1);
    send_word(OP_PRELOAD, 8'h5A, 2'd3, '1, 1'b1);
    send_word(OP_PRELOAD, 8'hA5, 2'd0, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_word(OP_MULTIPLY, 8'h00, 2'd1, '0, 1'b1);
    send_word(OP_CLEAR, 8'hFF, 2'd3, '1, 1'b1);
    send_word(OP_MULTIPLY, 8'h00, 2'd0, 64'h1, 1'b1);
  endtask

  task automatic test_register_extremes();
    // zero saturates to one row and one column
    wait_idle();
    write_regs('0, '0);
    send_word(OP_PRELOAD, 8'h00, 2'd3, '1, 1'b0);
    send_word(OP_PRELOAD, 8'h00, 2'd0, '1, 1'b0);
    send_word(OP_MULTIPLY, 8'h00, 2'd0, usable_bits(2'd0), 1'b0);
    send_word(OP_MULTIPLY, 8'h00, 2'd3, '1, 1'b1);
    // above the maximum saturates to full size; word 3 kept as preloaded until an XOR
    wait_idle();
    write_regs('1, CFG_W'(257));
    send_word(OP_MULTIPLY, 8'h00, 2'd1, '0, 1'b1);
    send_word(OP_MULTIPLY, 8'h00, 2'd3, 64'h8000_0000_0000_0000, 1'b1);
    // one column into the second word, rows of word 1 out of use
    wait_idle();
    write_regs(CFG_W'(64), CFG_W'(65));
    send_word(OP_MULTIPLY, 8'h00, 2'd1, '1, 1'b0);
    send_word(OP_MULTIPLY, 8'h00, 2'd0, 64'h1, 1'b1);
    wait_idle();
    write_regs(CFG_W'(2), CFG_W'(64));
    send_word(OP_MULTIPLY, 8'h00, 2'd0, usable_bits(2'd0), 1'b1);
  endtask

  task automatic test_random_traffic();
    int start;
    int r;
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      calm = (p % 3 == 2);
      write_regs(pick_reg_value(), pick_reg_value());
      start = n_items;
      while (n_items - start < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 30) write_full_row(pick_row());
        else if (r < 40) send_word(OP_WRITE, pick_row(), WI_W'($urandom_range(0, 3)),
                                   pick_data(), 1'($urandom_range(0, 1)));
        else if (r < 75) run_vector($urandom_range(1, 4), $urandom_range(0, 9) != 0);
        else if (r < 85) send_word(OP_PRELOAD, 8'($urandom), WI_W'($urandom_range(0, 3)),
                                   pick_data(), 1'($urandom_range(0, 1)));
        else if (r < 92) send_word(OP_CLEAR, 8'($urandom), WI_W'($urandom_range(0, 3)),
                                   rand64(), 1'($urandom_range(0, 1)));
        else run_vector(1, 1'b0);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_WRITE;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_ROWS;
    cfg_data_i    = '0;
    rows_reg      = CFG_W'(MAX_ROWS);
    cols_reg      = CFG_W'(MAX_COLS);
    for (int k = 0; k < ROW_WORDS; k++) acc_words[k] = '0;
    for (int r = 0; r < MAX_ROWS; r++)
      for (int k = 0; k < ROW_WORDS; k++) mat_written[r][k] = 1'b0;
    n_items       = 0;
    n_results     = 0;
    n_errors      = 0;
    n_settings    = 0;
    cycle_count   = 0;
    rx_stall_left = 0;
    calm          = 1'b1;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed_ops();
    calm = 1'b0;
    test_register_extremes();
    test_random_traffic();
    wait_idle();

    $display("Run covered %0d input words, %0d result words, %0d register settings",
             n_items, n_results, n_settings);
    $display("All four ops, saturated registers and partial-word column masks exercised");
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches found", n_errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
